FILE: src/fnmc_pkg.sv
package fnmc_pkg;

   localparam int NUM_BINS   = 34;
   localparam int BIN_W      = 6;
   localparam int COUNT_W    = 64;

   typedef enum logic {
      CMD_COUNT = 1'b0,
      CMD_READ  = 1'b1
   } command_type;

   // Motif classes in bin order; the last member tallies unclassified candidates.
   typedef enum logic [BIN_W-1:0] {
      CLS_4_1_1, CLS_4_1_2, CLS_4_1_3, CLS_4_1_4, CLS_4_1_5,
      CLS_4_1_6, CLS_4_1_7, CLS_4_1_8, CLS_4_1_9, CLS_4_1_10,
      CLS_4_2_1, CLS_4_2_2, CLS_4_2_3, CLS_4_2_4, CLS_4_2_5,
      CLS_4_2_6, CLS_4_2_7,
      CLS_4_3_1, CLS_4_3_2, CLS_4_3_3, CLS_4_3_4, CLS_4_3_5,
      CLS_4_3_6,
      CLS_4_4_1, CLS_4_4_2, CLS_4_4_3, CLS_4_4_0,
      CLS_4_5_1, CLS_4_5_2,
      CLS_4_6_1, CLS_4_6_2, CLS_4_6_3, CLS_4_6_4,
      CLS_NONE
   } class_type;

   function automatic class_type classify(input logic [1:0] ab, input logic [1:0] ac,
                                          input logic [1:0] ad, input logic [1:0] bc,
                                          input logic [1:0] bd, input logic [1:0] cd);
      logic      lab, lac, lad, lbc, lbd, lcd;
      logic      hub, all1, all2, sum1, sum3, sum4, sum5;
      logic [2:0] deg;
      logic [4:0] tot;
      logic [3:0] sa, sb, sc, sd;
      class_type  r;
      lab = (ab != 2'd0);
      lac = (ac != 2'd0);
      lad = (ad != 2'd0);
      lbc = (bc != 2'd0);
      lbd = (bd != 2'd0);
      lcd = (cd != 2'd0);
      deg = {2'b00, lab} + {2'b00, lac} + {2'b00, lad}
          + {2'b00, lbc} + {2'b00, lbd} + {2'b00, lcd};
      tot = {3'b000, ab} + {3'b000, ac} + {3'b000, ad}
          + {3'b000, bc} + {3'b000, bd} + {3'b000, cd};
      // per-node distance sums
      sa = {2'b00, ab} + {2'b00, ac} + {2'b00, ad};
      sb = {2'b00, ab} + {2'b00, bc} + {2'b00, bd};
      sc = {2'b00, ac} + {2'b00, bc} + {2'b00, cd};
      sd = {2'b00, ad} + {2'b00, bd} + {2'b00, cd};
      hub = (lab && lac && lad) || (lab && lbc && lbd) ||
            (lac && lbc && lcd) || (lad && lbd && lcd);
      all1 = (ab == 2'd1 && ac == 2'd1 && ad == 2'd1) ||
             (ab == 2'd1 && bc == 2'd1 && bd == 2'd1) ||
             (ac == 2'd1 && bc == 2'd1 && cd == 2'd1) ||
             (ad == 2'd1 && bd == 2'd1 && cd == 2'd1);
      all2 = (ab == 2'd2 && ac == 2'd2 && ad == 2'd2) ||
             (ab == 2'd2 && bc == 2'd2 && bd == 2'd2) ||
             (ac == 2'd2 && bc == 2'd2 && cd == 2'd2) ||
             (ad == 2'd2 && bd == 2'd2 && cd == 2'd2);
      sum1 = (sa == 4'd1) || (sb == 4'd1) || (sc == 4'd1) || (sd == 4'd1);
      sum3 = (sa == 4'd3) || (sb == 4'd3) || (sc == 4'd3) || (sd == 4'd3);
      sum4 = (sa == 4'd4) || (sb == 4'd4) || (sc == 4'd4) || (sd == 4'd4);
      sum5 = (sa == 4'd5) || (sb == 4'd5) || (sc == 4'd5) || (sd == 4'd5);
      r = CLS_NONE;
      case (deg)
         3'd6: begin
            case (tot)
               5'd12:   r = CLS_4_1_1;
               5'd11:   r = CLS_4_1_2;
               5'd10:   r = all2 ? CLS_4_1_4 : CLS_4_1_3;
               5'd9:    r = all1 ? CLS_4_1_6 : CLS_4_1_5;
               5'd8:    r = all1 ? CLS_4_1_8 : CLS_4_1_7;
               5'd7:    r = CLS_4_1_9;
               default: r = CLS_4_1_10;
            endcase
         end
         3'd5: begin
            case (tot)
               5'd10:   r = CLS_4_2_1;
               5'd9:    r = all2 ? CLS_4_2_3 : CLS_4_2_2;
               5'd8:    r = sum4 ? CLS_4_2_5 : CLS_4_2_4;
               5'd7:    r = sum3 ? CLS_4_2_7 : CLS_4_2_6;
               default: r = CLS_NONE;
            endcase
         end
         3'd4: begin
            if (hub) begin
               case (tot)
                  5'd8:    r = CLS_4_3_1;
                  5'd7:    r = sum3 ? CLS_4_3_3 : CLS_4_3_2;
                  5'd6:    r = sum5 ? CLS_4_3_5 : CLS_4_3_4;
                  5'd5:    r = CLS_4_3_6;
                  default: r = CLS_NONE;
               endcase
            end else begin
               case (tot)
                  5'd8:    r = CLS_4_4_1;
                  5'd7:    r = CLS_4_4_2;
                  5'd6:    r = CLS_4_4_3;
                  default: r = CLS_4_4_0;
               endcase
            end
         end
         3'd3: begin
            if (hub) begin
               case (tot)
                  5'd6:    r = CLS_4_5_1;
                  5'd5:    r = CLS_4_5_2;
                  default: r = CLS_NONE;
               endcase
            end else begin
               case (tot)
                  5'd6:    r = CLS_4_6_1;
                  5'd5:    r = sum1 ? CLS_4_6_2 : CLS_4_6_3;
                  5'd4:    r = CLS_4_6_4;
                  default: r = CLS_NONE;
               endcase
            end
         end
         default: r = CLS_NONE;
      endcase
      return r;
   endfunction

endpackage

FILE: src/fnmc_if.sv
interface fnmc_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [1:0] dist_ab;
   logic [1:0] dist_ac;
   logic [1:0] dist_ad;
   logic [1:0] dist_bc;
   logic [1:0] dist_bd;
   logic [1:0] dist_cd;
   logic [5:0] bin_index;

   modport source (output valid, command, dist_ab, dist_ac, dist_ad, dist_bc, dist_bd,
                   dist_cd, bin_index, input ready);
   modport sink (input valid, command, dist_ab, dist_ac, dist_ad, dist_bc, dist_bd,
                 dist_cd, bin_index, output ready);
endinterface

interface fnmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  class_code;
   logic [63:0] count_value;

   modport source (output valid, class_code, count_value, input ready);
   modport sink (input valid, class_code, count_value, output ready);
endinterface

FILE: src/four_node_motif_classifier.sv
// Pipeline: a transferred request passes the read stage, then the update stage.
// Throughput: one request per cycle unless a full output register stalls; set by the
//   single read and single write port of the counter memory, last write forwarded.
// Reset (synchronous, active high): per-bin valid bits clear at once, so every
//   counter reads as zero straight after reset; no clearing pass, ready next cycle.
module four_node_motif_classifier (
   input logic       clock,
   input logic       reset,
   fnmc_req_if.sink  req_ch,
   fnmc_rsp_if.source rsp_ch
);
   import fnmc_pkg::*;

   // ---------------------------------------------------------------------------
   // Stage 0: classify and issue the counter read
   // ---------------------------------------------------------------------------
   logic             req_fire;
   class_type        s0_cls;
   logic             s0_in_range;
   logic [BIN_W-1:0] s0_addr;

   assign req_fire = req_ch.valid && req_ch.ready;

   always_comb begin
      s0_cls = classify(req_ch.dist_ab, req_ch.dist_ac, req_ch.dist_ad,
                        req_ch.dist_bc, req_ch.dist_bd, req_ch.dist_cd);
      s0_in_range = (req_ch.bin_index < BIN_W'(NUM_BINS));
      if (req_ch.command == CMD_READ) begin
         // out-of-range reads go to bin 0 and are zeroed later
         s0_addr = s0_in_range ? req_ch.bin_index : '0;
      end else begin
         s0_addr = s0_cls;
      end
   end

   // ---------------------------------------------------------------------------
   // Counter memory: one read and one write per cycle, read data registered.
   // Valid bits stand in for clearing the array at reset.
   // ---------------------------------------------------------------------------
   logic [COUNT_W-1:0]  cnt_mem [NUM_BINS];
   logic [NUM_BINS-1:0] bin_vld_ff;
   logic [NUM_BINS-1:0] bin_vld_in;
   logic [COUNT_W-1:0]  rd_data_ff;
   logic                rd_vld_ff;

   // Stage 1 registers
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_cmd_ff;
   logic             s1_in_range_ff;
   logic [BIN_W-1:0] s1_addr_ff;
   logic [BIN_W-1:0] s1_cls_ff;

   // Last write, forwarded to any access of its bin, also one that read in the same cycle
   logic               fwd_valid_ff, fwd_valid_in;
   logic [BIN_W-1:0]   fwd_addr_ff;
   logic [COUNT_W-1:0] fwd_data_ff;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]   rsp_class_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // ---------------------------------------------------------------------------
   // Stage 1: read-modify-write
   // ---------------------------------------------------------------------------
   logic               s1_adv;
   logic               s1_write;
   logic [COUNT_W-1:0] s1_base;
   logic [COUNT_W-1:0] s1_inc;
   logic [COUNT_W-1:0] s1_count;

   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign s1_write = s1_adv && (s1_cmd_ff == CMD_COUNT);

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         s1_base = fwd_data_ff;
      end else if (rd_vld_ff) begin
         s1_base = rd_data_ff;
      end else begin
         s1_base = '0;
      end
      s1_inc = s1_base + COUNT_W'(1);   // wraps modulo 2^64
      if (s1_cmd_ff == CMD_READ) begin
         s1_count = s1_in_range_ff ? s1_base : '0;
      end else begin
         s1_count = s1_inc;
      end
   end

   // stall only when the update stage is held by a full output register
   assign req_ch.ready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : ((rsp_valid_ff && rsp_ch.ready) ? 1'b0 : rsp_valid_ff);
      fwd_valid_in = s1_write ? 1'b1 : fwd_valid_ff;
      bin_vld_in   = bin_vld_ff;
      if (s1_write) begin
         bin_vld_in[s1_addr_ff] = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         bin_vld_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         bin_vld_ff   <= bin_vld_in;
      end
   end

   // memory port and payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff     <= cnt_mem[s0_addr];
         rd_vld_ff      <= bin_vld_ff[s0_addr];
         s1_cmd_ff      <= req_ch.command;
         s1_in_range_ff <= s0_in_range;
         s1_addr_ff     <= s0_addr;
         s1_cls_ff      <= (req_ch.command == CMD_READ) ? BIN_W'(CLS_NONE) : s0_cls;
      end
      if (s1_write) begin
         cnt_mem[s1_addr_ff] <= s1_inc;
         fwd_addr_ff         <= s1_addr_ff;
         fwd_data_ff         <= s1_inc;
      end
      if (s1_adv) begin
         rsp_class_ff <= s1_cls_ff;
         rsp_count_ff <= s1_count;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.class_code  = rsp_class_ff;
   assign rsp_ch.count_value = rsp_count_ff;

endmodule

FILE: src/fnmc_checker.sv
module fnmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_class_code,
   input logic [63:0] rsp_count_value
);
   import fnmc_pkg::*;

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_class_code)
                                  && $stable(rsp_count_value))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // back-pressure only comes from a full, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without output back-pressure");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_class_code <= 6'(CLS_NONE))
      else $error("class code out of range");

   // idle input after reset stays idle on the output
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !$past(req_valid) |-> !rsp_valid)
      else $error("response without request");

endmodule

bind four_node_motif_classifier fnmc_checker u_fnmc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_class_code  (rsp_ch.class_code),
   .rsp_count_value (rsp_ch.count_value)
);
